### rtl/core/tfn_pkg.sv
// tfn_pkg: shared types, widths and register codes for the face normal block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

  localparam int CoordW = 24;
  localparam int EdgeW  = 25;
  localparam int CrossW = 51;
  localparam int MagW   = 30;
  localparam int SqW    = 62;
  localparam int LenW   = 31;
  localparam int NormW  = 16;
  localparam int DivW   = 46;   // numerator width: a << 15 plus len
  localparam int QuoW   = 16;   // quotient bits developed by the divider chain

  localparam logic [0:0] REG_INVERT = 1'b0;

  typedef struct packed {
    logic signed [CoordW-1:0] p0_x;
    logic signed [CoordW-1:0] p0_y;
    logic signed [CoordW-1:0] p0_z;
    logic signed [CoordW-1:0] p1_x;
    logic signed [CoordW-1:0] p1_y;
    logic signed [CoordW-1:0] p1_z;
    logic signed [CoordW-1:0] p2_x;
    logic signed [CoordW-1:0] p2_y;
    logic signed [CoordW-1:0] p2_z;
  } in_word_t;

  typedef struct packed {
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    degenerate;
  } out_word_t;

  // token that travels the sqrt chain
  typedef struct packed {
    logic                 vld;
    logic [2:0]           neg;
    logic                 degen;
    logic [MagW-1:0]      a0;
    logic [MagW-1:0]      a1;
    logic [MagW-1:0]      a2;
    logic [SqW-1:0]       rem;
    logic [SqW-1:0]       res;
  } sq_tok_t;

  // token that travels the divide chain
  typedef struct packed {
    logic                 vld;
    logic [2:0]           neg;
    logic                 degen;
    logic [LenW:0]        den;
    logic [DivW-1:0]      r0;
    logic [DivW-1:0]      r1;
    logic [DivW-1:0]      r2;
    logic [QuoW-1:0]      q0;
    logic [QuoW-1:0]      q1;
    logic [QuoW-1:0]      q2;
  } dv_tok_t;

endpackage
`default_nettype wire

### rtl/core/triangle_face_normal_top.sv
// triangle_face_normal_top: face normal pipeline, cross product to unit vector
// depends on tfn_pkg, tfn_sqrt_cell, tfn_div_cell
// registered stages in order: edges, products, cross, normalize, squares, 31 sqrt cells,
// 16 div cells, out
// throughput one triangle per cycle; the whole chain stalls only when the output is held
// reset clears every stage valid bit and the invert register
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal_top
  import tfn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data,
  input  wire logic      cfg_psel,
  input  wire logic      cfg_penable,
  input  wire logic      cfg_pwrite,
  input  wire logic [1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready
);

  localparam int NSq = 31;

  // chain advances unless a result sits unread at the output
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // config register
  logic inv_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr[1] == REG_INVERT) begin
      inv_r <= cfg_pwdata[0];
    end
  end
  assign cfg_prdata = (cfg_paddr[1] == REG_INVERT) ? {31'd0, inv_r} : 32'd0;

  // stage 1: edges
  logic v1_r;
  logic signed [EdgeW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
    if (en) begin
      e1x_r <= EdgeW'(in_data.p1_x) - EdgeW'(in_data.p0_x);
      e1y_r <= EdgeW'(in_data.p1_y) - EdgeW'(in_data.p0_y);
      e1z_r <= EdgeW'(in_data.p1_z) - EdgeW'(in_data.p0_z);
      e2x_r <= EdgeW'(in_data.p2_x) - EdgeW'(in_data.p0_x);
      e2y_r <= EdgeW'(in_data.p2_y) - EdgeW'(in_data.p0_y);
      e2z_r <= EdgeW'(in_data.p2_z) - EdgeW'(in_data.p0_z);
    end
  end

  // stage 2: six 25x25 products
  logic v2_r;
  logic signed [2*EdgeW-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      m0_r <= e1y_r * e2z_r;
      m1_r <= e1z_r * e2y_r;
      m2_r <= e1z_r * e2x_r;
      m3_r <= e1x_r * e2z_r;
      m4_r <= e1x_r * e2y_r;
      m5_r <= e1y_r * e2x_r;
    end
  end

  // stage 3: cross product magnitudes and signs
  logic v3_r;
  logic [CrossW-1:0] c0, c1, c2;
  logic [CrossW-1:0] a0_r, a1_r, a2_r;
  logic [2:0] sg_r;
  always_comb begin
    c0 = CrossW'(m0_r) - CrossW'(m1_r);
    c1 = CrossW'(m2_r) - CrossW'(m3_r);
    c2 = CrossW'(m4_r) - CrossW'(m5_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      sg_r <= {c2[CrossW-1], c1[CrossW-1], c0[CrossW-1]};
      a0_r <= c0[CrossW-1] ? -c0 : c0;
      a1_r <= c1[CrossW-1] ? -c1 : c1;
      a2_r <= c2[CrossW-1] ? -c2 : c2;
    end
  end

  // stage 4: common shift so the largest lands in [2^29, 2^30)
  logic [CrossW-1:0] orv;
  logic [5:0] lead;
  logic [CrossW+MagW-1:0] sh0, sh1, sh2;
  always_comb begin
    orv  = a0_r | a1_r | a2_r;
    lead = 6'd0;
    for (int i = 0; i < CrossW; i++) begin
      if (orv[i]) lead = 6'(i);
    end
    sh0 = {a0_r, {MagW{1'b0}}} >> (lead + 6'd1);
    sh1 = {a1_r, {MagW{1'b0}}} >> (lead + 6'd1);
    sh2 = {a2_r, {MagW{1'b0}}} >> (lead + 6'd1);
  end

  sq_tok_t sq [NSq+1];
  logic [2:0] negi;
  assign negi = inv_r ? ~sg_r : sg_r;

  logic [SqW-1:0] s0_nxt, s1_nxt, s2_nxt;
  sq_tok_t t4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) t4_r.vld <= 1'b0;
    else if (en) t4_r.vld <= v3_r;
    if (en) begin
      t4_r.neg   <= negi;
      t4_r.degen <= (orv == '0);
      t4_r.a0    <= sh0[MagW-1:0];
      t4_r.a1    <= sh1[MagW-1:0];
      t4_r.a2    <= sh2[MagW-1:0];
      t4_r.rem   <= '0;
      t4_r.res   <= '0;
    end
  end

  // stage 5: sum of squares
  always_comb begin
    s0_nxt = SqW'(t4_r.a0) * SqW'(t4_r.a0);
    s1_nxt = SqW'(t4_r.a1) * SqW'(t4_r.a1);
    s2_nxt = SqW'(t4_r.a2) * SqW'(t4_r.a2);
  end
  logic v5_r;
  sq_tok_t t5_r;
  logic [SqW-1:0] q0_r, q1_r, q2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= t4_r.vld;
    if (en) begin
      t5_r <= t4_r;
      q0_r <= s0_nxt;
      q1_r <= s1_nxt;
      q2_r <= s2_nxt;
    end
  end
  always_comb begin
    sq[0]     = t5_r;
    sq[0].vld = v5_r;
    sq[0].rem = q0_r + q1_r + q2_r;
    sq[0].res = '0;
  end

  for (genvar g = 0; g < NSq; g++) begin : g_sq
    tfn_sqrt_cell #(.Step(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .tok_in(sq[g]), .tok_out(sq[g+1])
    );
  end

  dv_tok_t dv [QuoW+1];
  logic [LenW-1:0] len;
  assign len = sq[NSq].res[LenW-1:0];
  always_comb begin
    dv[0]       = '0;
    dv[0].vld   = sq[NSq].vld;
    dv[0].neg   = sq[NSq].neg;
    dv[0].degen = sq[NSq].degen;
    dv[0].den   = {len, 1'b0};
    dv[0].r0    = (DivW'(sq[NSq].a0) << 15) + DivW'(len);
    dv[0].r1    = (DivW'(sq[NSq].a1) << 15) + DivW'(len);
    dv[0].r2    = (DivW'(sq[NSq].a2) << 15) + DivW'(len);
  end

  for (genvar g = 0; g < QuoW; g++) begin : g_dv
    tfn_div_cell #(.Step(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .tok_in(dv[g]), .tok_out(dv[g+1])
    );
  end

  // output register: clamp, sign, degenerate override
  function automatic logic [NormW-1:0] fin(input logic [QuoW-1:0] q, input logic n,
                                           input logic dg);
    logic [NormW-1:0] m;
    begin
      m = (q > 16'd16384) ? 16'd16384 : q;
      fin = dg ? '0 : (n ? -m : m);
    end
  endfunction

  dv_tok_t tl;
  assign tl = dv[QuoW];
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= tl.vld;
    if (en) begin
      out_data.normal_x   <= fin(tl.q0, tl.neg[0], tl.degen);
      out_data.normal_y   <= fin(tl.q1, tl.neg[1], tl.degen);
      out_data.normal_z   <= fin(tl.q2, tl.neg[2], tl.degen);
      out_data.degenerate <= tl.degen;
    end
  end

endmodule
`default_nettype wire

### rtl/core/tfn_sqrt_cell.sv
// tfn_sqrt_cell: one digit step of the restoring square root chain
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none
module tfn_sqrt_cell
  import tfn_pkg::*;
#(
  parameter int Step = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire sq_tok_t tok_in,
  output sq_tok_t      tok_out
);

  localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (30 - Step));

  sq_tok_t tok_r, tok_nxt;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.rem >= tok_in.res + Bit) begin
      tok_nxt.rem = tok_in.rem - (tok_in.res + Bit);
      tok_nxt.res = (tok_in.res >> 1) + Bit;
    end else begin
      tok_nxt.res = tok_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

### rtl/core/tfn_div_cell.sv
// tfn_div_cell: one quotient bit of three restoring dividers sharing a divisor
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none
module tfn_div_cell
  import tfn_pkg::*;
#(
  parameter int Step = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire dv_tok_t tok_in,
  output dv_tok_t      tok_out
);

  localparam int Sh = QuoW - 1 - Step;
  localparam int ExtW = DivW + QuoW;

  function automatic logic [DivW-1:0] sub_step(input logic [DivW-1:0] r,
                                               input logic [LenW:0] d,
                                               output logic q);
    logic [ExtW-1:0] dd;
    begin
      dd = ExtW'(d) << Sh;
      q  = (ExtW'(r) >= dd);
      sub_step = q ? DivW'(ExtW'(r) - dd) : r;
    end
  endfunction

  dv_tok_t tok_r, tok_nxt;
  logic b0, b1, b2;

  always_comb begin
    tok_nxt = tok_in;
    tok_nxt.r0 = sub_step(tok_in.r0, tok_in.den, b0);
    tok_nxt.r1 = sub_step(tok_in.r1, tok_in.den, b1);
    tok_nxt.r2 = sub_step(tok_in.r2, tok_in.den, b2);
    tok_nxt.q0[Sh] = b0;
    tok_nxt.q1[Sh] = b1;
    tok_nxt.q2[Sh] = b2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire
